### rtl/core/rgbhsv_pkg.sv
// Shared widths, constants and types for the RGB to HSV pipeline.
`timescale 1ns / 1ps

package rgbhsv_pkg;

    // Field widths
    localparam int CHAN_W = 8;
    localparam int HUE_W  = 9;
    localparam int MILLI_W = 10;

    // Arithmetic constants
    localparam int DEG_SECTOR = 60;
    localparam int DEG_FULL   = 360;
    localparam int MILLI      = 1000;
    localparam int CHAN_MAX   = 255;

    // Divider geometry: numerator, divisor and quotient widths, bits per stage and stage count
    localparam int HNUM_W         = 17;
    localparam int NUM_W          = 19;
    localparam int DIV_W          = CHAN_W + 1;
    localparam int QUO_W          = 10;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

    // Divider lanes
    localparam int LANES    = 2;
    localparam int LANE_HUE = 0;
    localparam int LANE_SAT = 1;

    // Value by reciprocal multiplication: (max * 2000 + 255) / 510, exact for 8-bit max
    localparam int     VAL_SH     = 28;
    localparam longint VAL_RECIP  = ((longint'(1) << VAL_SH) + 2 * CHAN_MAX - 1)
                                    / (2 * CHAN_MAX);
    localparam longint VAL_MUL    = 2 * MILLI * VAL_RECIP;
    localparam longint VAL_ADD    = CHAN_MAX * VAL_RECIP;
    localparam int     VAL_PROD_W = 39;

    typedef logic [NUM_W-1:0] num_t;
    typedef logic [DIV_W-1:0] dvs_t;
    typedef logic [QUO_W-1:0] quo_t;

    typedef struct packed {
        num_t num;
        dvs_t dvs;
    } div_lane_t;

endpackage

### rtl/core/rgbhsv_front.sv
// Front end: max, min, delta and sector, then the division operands.
`timescale 1ns / 1ps

module rgbhsv_front
    import rgbhsv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CHAN_W-1:0]     red_in,
    input  logic [CHAN_W-1:0]     green_in,
    input  logic [CHAN_W-1:0]     blue_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output div_lane_t [LANES-1:0] lanes,
    output logic                  grey,
    output logic [MILLI_W-1:0]    val
);

    localparam logic [1:0] SEC_RED = 2'd0;
    localparam logic [1:0] SEC_GRN = 2'd1;
    localparam logic [1:0] SEC_BLU = 2'd2;

    typedef struct packed {
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] delta;
        logic [CHAN_W-1:0] mag;
        logic              neg;
        logic [1:0]        sector;
    } pix_t;

    pix_t                  pix_next;
    pix_t                  pix_reg;
    logic                  pix_valid_reg;
    logic [CHAN_W-1:0]     mn;
    logic [HUE_W-1:0]      base;
    logic [HNUM_W-1:0]     base_mul;
    logic [HNUM_W-1:0]     sixty_mul;
    logic [HNUM_W-1:0]     hnum;
    logic [VAL_PROD_W-1:0] val_prod;
    div_lane_t [LANES-1:0] lanes_next;
    div_lane_t [LANES-1:0] lanes_reg;
    logic                  grey_reg;
    logic [MILLI_W-1:0]    val_reg;
    logic                  opnd_valid_reg;
    logic                  opnd_ready;
    logic                  pix_ready;

    // Advance a stage when it is empty or the next one advances
    assign opnd_ready = !opnd_valid_reg || out_ready;
    assign pix_ready  = !pix_valid_reg || opnd_ready;
    assign in_ready   = pix_ready;

    // Pick the sector of the largest channel, red over green over blue
    always_comb
    begin
        pix_next = '0;
        mn = red_in;
        if (green_in < mn)
        begin
            mn = green_in;
        end
        if (blue_in < mn)
        begin
            mn = blue_in;
        end
        if (red_in >= green_in && red_in >= blue_in)
        begin
            pix_next.sector = SEC_RED;
            pix_next.mx     = red_in;
            pix_next.neg    = green_in < blue_in;
            pix_next.mag    = pix_next.neg ? blue_in - green_in : green_in - blue_in;
        end
        else if (green_in >= blue_in)
        begin
            pix_next.sector = SEC_GRN;
            pix_next.mx     = green_in;
            pix_next.neg    = blue_in < red_in;
            pix_next.mag    = pix_next.neg ? red_in - blue_in : blue_in - red_in;
        end
        else
        begin
            pix_next.sector = SEC_BLU;
            pix_next.mx     = blue_in;
            pix_next.neg    = red_in < green_in;
            pix_next.mag    = pix_next.neg ? green_in - red_in : red_in - green_in;
        end
        pix_next.delta = pix_next.mx - mn;
    end

    // Sector base angle; a negative red offset counts down from the full turn
    always_comb
    begin
        unique case (pix_reg.sector)
            SEC_RED: base = pix_reg.neg ? HUE_W'(DEG_FULL) : '0;
            SEC_GRN: base = HUE_W'(2 * DEG_SECTOR);
            SEC_BLU: base = HUE_W'(4 * DEG_SECTOR);
            default: base = '0;
        endcase
    end

    // Build numerators and divisors with the rounding half-divisor folded in
    always_comb
    begin
        base_mul  = HNUM_W'(base) * HNUM_W'(pix_reg.delta);
        sixty_mul = HNUM_W'(pix_reg.mag) * HNUM_W'(DEG_SECTOR);
        hnum      = pix_reg.neg ? base_mul - sixty_mul : base_mul + sixty_mul;

        lanes_next[LANE_HUE].num = NUM_W'({hnum, 1'b0}) + NUM_W'(pix_reg.delta);
        lanes_next[LANE_HUE].dvs = {pix_reg.delta, 1'b0};
        lanes_next[LANE_SAT].num = NUM_W'(pix_reg.delta) * NUM_W'(2 * MILLI)
                                   + NUM_W'(pix_reg.mx);
        lanes_next[LANE_SAT].dvs = {pix_reg.mx, 1'b0};
    end

    // Scale max to thousandths of full range by a reciprocal multiply
    assign val_prod = VAL_PROD_W'(pix_reg.mx) * VAL_PROD_W'(VAL_MUL) + VAL_PROD_W'(VAL_ADD);

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg  <= 1'b0;
            opnd_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_ready)
            begin
                pix_valid_reg <= in_valid;
            end
            if (opnd_ready)
            begin
                opnd_valid_reg <= pix_valid_reg;
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (pix_ready)
        begin
            pix_reg <= pix_next;
        end
        if (opnd_ready)
        begin
            lanes_reg <= lanes_next;
            grey_reg  <= pix_reg.delta == '0;
            val_reg   <= val_prod[VAL_SH +: MILLI_W];
        end
    end

    assign out_valid = opnd_valid_reg;
    assign lanes     = lanes_reg;
    assign grey      = grey_reg;
    assign val       = val_reg;

endmodule

### rtl/core/rgbhsv_div.sv
// Pipelined restoring divider: two lanes, two quotient bits per stage, value alongside.
`timescale 1ns / 1ps

module rgbhsv_div
    import rgbhsv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  div_lane_t [LANES-1:0] lanes,
    input  logic                  grey,
    input  logic [MILLI_W-1:0]    val,
    output logic                  out_valid,
    input  logic                  out_ready,
    output quo_t [LANES-1:0]      quo,
    output logic                  out_grey,
    output logic [MILLI_W-1:0]    out_val
);

    num_t                  rem_reg  [DIV_STAGES][LANES];
    dvs_t                  dvs_reg  [DIV_STAGES][LANES];
    quo_t                  quo_reg  [DIV_STAGES][LANES];
    logic [MILLI_W-1:0]    val_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0] grey_reg;
    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES:0]   ready;

    // Ready ripples back through full stages; an empty stage is always ready
    assign ready[DIV_STAGES] = out_ready;
    assign in_ready          = ready[0];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        localparam int SH_TOP = QUO_W - 1 - BITS_PER_STAGE * s;

        num_t rem_in  [LANES];
        dvs_t dvs_in  [LANES];
        quo_t quo_in  [LANES];
        num_t rem_nx  [LANES];
        quo_t quo_nx  [LANES];
        logic v_in;
        logic grey_in;
        logic [MILLI_W-1:0] val_in;

        assign ready[s] = !valid_reg[s] || ready[s+1];

        // Select the stage source
        if (s == 0)
        begin : g_head
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_in[l] = lanes[l].num;
                    dvs_in[l] = lanes[l].dvs;
                    quo_in[l] = '0;
                end
                v_in    = in_valid;
                grey_in = grey;
                val_in  = val;
            end
        end
        else
        begin : g_body
            always_comb
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_in[l] = rem_reg[s-1][l];
                    dvs_in[l] = dvs_reg[s-1][l];
                    quo_in[l] = quo_reg[s-1][l];
                end
                v_in    = valid_reg[s-1];
                grey_in = grey_reg[s-1];
                val_in  = val_reg[s-1];
            end
        end

        // Trial-subtract the shifted divisor, one quotient bit per step
        always_comb
        begin
            num_t rem_w;
            num_t shd;
            quo_t q_w;
            for (int l = 0; l < LANES; l++)
            begin
                rem_w = rem_in[l];
                q_w   = quo_in[l];
                for (int k = 0; k < BITS_PER_STAGE; k++)
                begin
                    shd = NUM_W'(dvs_in[l]) << (SH_TOP - k);
                    if (rem_w >= shd)
                    begin
                        rem_w = rem_w - shd;
                        q_w   = {q_w[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q_w = {q_w[QUO_W-2:0], 1'b0};
                    end
                end
                rem_nx[l] = rem_w;
                quo_nx[l] = q_w;
            end
        end

        // Hold the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (ready[s])
            begin
                valid_reg[s] <= v_in;
            end
        end

        // Advance payload
        always_ff @(posedge clk)
        begin
            if (ready[s])
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s][l] <= rem_nx[l];
                    dvs_reg[s][l] <= dvs_in[l];
                    quo_reg[s][l] <= quo_nx[l];
                end
                grey_reg[s] <= grey_in;
                val_reg[s]  <= val_in;
            end
        end
    end

    // Drive the last stage out
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo[l] = quo_reg[DIV_STAGES-1][l];
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_grey  = grey_reg[DIV_STAGES-1];
    assign out_val   = val_reg[DIV_STAGES-1];

endmodule

### rtl/core/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter: front end, divider and output register.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------
//   rgb     | rgb_valid | rgb_stall | red_in, green_in, blue_in
//   hsv     | hsv_valid | hsv_stall | hue_deg, sat_milli, val_milli
//
// One pixel per clock sustained while hsv_stall stays low; a request reaches
// hsv_valid through two front stages (value by reciprocal multiply in the second),
// five divider stages (two quotient bits each for hue and saturation in
// parallel, value riding alongside) and the output register.
// Reset clears only the valid bits; payload registers are left as they are.
// Stall ripples back only through full stages, so empty slots absorb requests
// while a result waits; rgb_stall rises only when every stage is occupied.
`timescale 1ns / 1ps

module rgb_to_hsv_converter
    import rgbhsv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rgb_valid,
    output logic               rgb_stall,
    input  logic [CHAN_W-1:0]  red_in,
    input  logic [CHAN_W-1:0]  green_in,
    input  logic [CHAN_W-1:0]  blue_in,
    output logic               hsv_valid,
    input  logic               hsv_stall,
    output logic [HUE_W-1:0]   hue_deg,
    output logic [MILLI_W-1:0] sat_milli,
    output logic [MILLI_W-1:0] val_milli
);

    div_lane_t [LANES-1:0] lanes;
    quo_t [LANES-1:0]      quo;
    logic                  front_ready;
    logic                  opnd_valid;
    logic                  opnd_grey;
    logic [MILLI_W-1:0]    opnd_val;
    logic                  div_ready;
    logic                  div_valid;
    logic                  div_grey;
    logic [MILLI_W-1:0]    div_val;
    logic                  out_ready;
    quo_t                  hue_wrap;
    logic                  hsv_valid_reg;
    logic [HUE_W-1:0]      hue_reg;
    logic [MILLI_W-1:0]    sat_reg;
    logic [MILLI_W-1:0]    val_reg;

    rgbhsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rgb_valid),
        .in_ready  (front_ready),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (opnd_valid),
        .out_ready (div_ready),
        .lanes     (lanes),
        .grey      (opnd_grey),
        .val       (opnd_val)
    );

    rgbhsv_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (opnd_valid),
        .in_ready  (div_ready),
        .lanes     (lanes),
        .grey      (opnd_grey),
        .val       (opnd_val),
        .out_valid (div_valid),
        .out_ready (out_ready),
        .quo       (quo),
        .out_grey  (div_grey),
        .out_val   (div_val)
    );

    assign rgb_stall = !front_ready;
    assign out_ready = !hsv_valid_reg || !hsv_stall;

    // Wrap a hue that rounds up to the full turn back to zero
    assign hue_wrap = (quo[LANE_HUE] >= QUO_W'(DEG_FULL))
                      ? quo[LANE_HUE] - QUO_W'(DEG_FULL) : quo[LANE_HUE];

    // Hold the output valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsv_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            hsv_valid_reg <= div_valid;
        end
    end

    // Load the result; a grey pixel drops hue and saturation to zero
    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            hue_reg <= div_grey ? '0 : hue_wrap[HUE_W-1:0];
            sat_reg <= div_grey ? '0 : quo[LANE_SAT];
            val_reg <= div_val;
        end
    end

    assign hsv_valid = hsv_valid_reg;
    assign hue_deg   = hue_reg;
    assign sat_milli = sat_reg;
    assign val_milli = val_reg;

endmodule

### rtl/core/rgbhsv_checker.sv
// Port-level checker for the RGB to HSV converter, bound to the top level.
`timescale 1ns / 1ps

module rgbhsv_checker
    import rgbhsv_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               rgb_valid,
    input logic               rgb_stall,
    input logic [CHAN_W-1:0]  red_in,
    input logic [CHAN_W-1:0]  green_in,
    input logic [CHAN_W-1:0]  blue_in,
    input logic               hsv_valid,
    input logic               hsv_stall,
    input logic [HUE_W-1:0]   hue_deg,
    input logic [MILLI_W-1:0] sat_milli,
    input logic [MILLI_W-1:0] val_milli
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && hsv_stall |=> hsv_valid)
    else $error("stalled result withdrawn");

    // Results stay within their ranges
    assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> hue_deg < HUE_W'(DEG_FULL) && sat_milli <= MILLI_W'(MILLI)
                      && val_milli <= MILLI_W'(MILLI))
    else $error("result out of range");

    // A nonzero hue only comes from a coloured pixel, which has saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && hue_deg != '0 |-> sat_milli != '0)
    else $error("hue without saturation");

    // Input stalls only when a result is held at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !hsv_valid |-> !rgb_stall)
    else $error("input stalled with empty output");

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .hsv_valid (hsv_valid),
    .hsv_stall (hsv_stall),
    .hue_deg   (hue_deg),
    .sat_milli (sat_milli),
    .val_milli (val_milli)
);
